### rtl/rtpst_pkg.sv
// rtpst_pkg: shared types and constants of the rtp sequence tracker
// widths, reset values, item kinds, register indexes, sequencer states
// used by every rtl file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rtpst_pkg;

  // counter and field widths
  localparam int COUNT_BITS = 32;
  localparam int CW         = COUNT_BITS;
  localparam int SEQ_W      = 16;
  localparam int BAD_W      = SEQ_W + 1;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int PROB_W     = 4;
  localparam int FRAC_W     = 8;
  localparam int KIND_W     = 2;

  // stream word layout
  localparam int IN_TDATA_W  = SEQ_W;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_DATA_W  = 1 + 3 * CW + FRAC_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

  // sequence space constants
  localparam logic [BAD_W-1:0] SEQ_MOD  = BAD_W'(65536);
  localparam logic [BAD_W-1:0] BAD_NONE = BAD_W'(65537);

  // reset values
  localparam logic [CFG_W-1:0]  MAX_DROPOUT_RST  = CFG_W'(3000);
  localparam logic [CFG_W-1:0]  MAX_MISORDER_RST = CFG_W'(100);
  localparam logic [PROB_W-1:0] MIN_SEQ_RST      = PROB_W'(2);
  localparam logic [PROB_W-1:0] PROB_RST         = PROB_W'(2);
  localparam logic [SEQ_W-1:0]  HIGHEST_RST      = {SEQ_W{1'b1}};

  // lost fraction divider
  localparam logic [FRAC_W-1:0] FRAC_SAT  = {FRAC_W{1'b1}};
  localparam int                DIV_CNT_W = $clog2(FRAC_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROPOUT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISORDER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEQ      = CFG_IDX_W'(2);

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PACKET = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PKT_WRAP,
    ST_PKT_RECV,
    ST_REP_EXT,
    ST_REP_BASE,
    ST_REP_EXP,
    ST_REP_LOST,
    ST_REP_EINT,
    ST_REP_RINT,
    ST_REP_LINT,
    ST_REP_SAT,
    ST_REP_DIV,
    ST_OUT
  } state_t;

  // packet decision handed from the checker to the sequencer
  typedef struct packed {
    logic set_high;
    logic prob_step;
    logic prob_fail;
    logic mark_bad;
    logic restart;
    logic wrap;
    logic count;
    logic order;
  } pkt_dec_t;

endpackage

`default_nettype wire

### rtl/rtpst_alu.sv
// rtpst_alu: shared add / subtract unit of the rtp sequence tracker
// one counter-wide add or subtract per cycle, with a no-borrow flag
// depends on rtpst_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtpst_alu (
  input  wire logic [rtpst_pkg::CW:0]   a,
  input  wire logic [rtpst_pkg::CW-1:0] b,
  input  wire logic                     sub,
  output logic      [rtpst_pkg::CW:0]   res,
  output logic                          ge
);

  logic [rtpst_pkg::CW:0]   b_ext;
  logic [rtpst_pkg::CW+1:0] sum;

  // two's complement subtract when sub is set
  assign b_ext = {1'b0, b} ^ {(rtpst_pkg::CW + 1){sub}};
  assign sum   = {1'b0, a} + {1'b0, b_ext} + {{(rtpst_pkg::CW + 1){1'b0}}, sub};
  assign res   = sum[rtpst_pkg::CW:0];

  // carry out of a subtract means a >= b
  assign ge = sub & sum[rtpst_pkg::CW+1];

endmodule

`default_nettype wire

### rtl/rtpst_pkt_check.sv
// rtpst_pkt_check: classifies one packet sequence number against the tracker state
// probation, forward gap, misorder window and resync checks on 16 bit values
// depends on rtpst_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtpst_pkt_check (
  input  wire logic [rtpst_pkg::SEQ_W-1:0]  seq,
  input  wire logic [rtpst_pkg::SEQ_W-1:0]  highest,
  input  wire logic [rtpst_pkg::BAD_W-1:0]  bad,
  input  wire logic [rtpst_pkg::PROB_W-1:0] prob,
  input  wire logic [rtpst_pkg::CFG_W-1:0]  dropout_max,
  input  wire logic [rtpst_pkg::CFG_W-1:0]  reorder_max,
  output rtpst_pkg::pkt_dec_t               dec
);

  logic [rtpst_pkg::SEQ_W-1:0] gap;
  logic [rtpst_pkg::SEQ_W-1:0] succ;
  logic [rtpst_pkg::BAD_W-1:0] misorder_lim;

  // distances in the 16 bit sequence space
  assign gap          = seq - highest;
  assign succ         = highest + rtpst_pkg::SEQ_W'(1);
  assign misorder_lim = rtpst_pkg::SEQ_MOD - rtpst_pkg::BAD_W'(reorder_max);

  // decision tree, first match wins
  always_comb begin
    dec = '0;
    if (prob != '0) begin
      dec.set_high = 1'b1;
      if (seq == succ) begin
        dec.prob_step = 1'b1;
        dec.order     = 1'b1;
        // last probation packet makes the source valid
        if (prob == rtpst_pkg::PROB_W'(1)) begin
          dec.restart = 1'b1;
          dec.count   = 1'b1;
        end
      end else begin
        dec.prob_fail = 1'b1;
      end
    end else if (gap < rtpst_pkg::SEQ_W'(dropout_max)) begin
      dec.set_high = 1'b1;
      dec.wrap     = (seq < highest);
      dec.count    = 1'b1;
      dec.order    = (gap == rtpst_pkg::SEQ_W'(1));
    end else if (rtpst_pkg::BAD_W'(gap) <= misorder_lim) begin
      // large jump: resync on the second packet in a row
      if (rtpst_pkg::BAD_W'(seq) == bad) begin
        dec.restart = 1'b1;
        dec.count   = 1'b1;
        dec.order   = (gap == rtpst_pkg::SEQ_W'(1));
      end else begin
        dec.mark_bad = 1'b1;
      end
    end else begin
      // duplicate or reordered packet: rejected
      dec = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/rtp_sequence_tracker.sv
// rtp_sequence_tracker: rtp receiver sequence tracking (top level)
// depends on rtpst_pkg, rtpst_alu and rtpst_pkt_check
//
// in channel: one word per item, in_tuser = kind (packet, report, start),
// in_tdata = sequence number. out channel: one word per item with in_order,
// extended highest, expected count, cumulative loss and lost fraction.
// cfg port: plain write of the dropout limit, the misorder limit and the
// probation length; the user is to write it only while no item is in flight,
// which the block does not enforce. one item is handled at a time; in_tready is
// high only while idle. after the accept every item is decoded; a start, an
// unused kind or an uncounted packet then goes to the result word, a counted
// packet first updates the received count, one with a 64k wrap first the wrap
// count and then the received count; a report runs the extended highest,
// expected, lost and interval steps, then the saturation check and, when the
// lost fraction needs it, the 8-step restoring divide. the shared add / subtract
// unit performs one counter-wide step per cycle. the next item is taken the
// cycle after the result word leaves; a stalled receiver holds it and the block.
// reset (rst_n low, synchronous) restores the default registers, puts the
// source in probation and clears all counters.
`timescale 1ns / 1ps
`default_nettype none

module rtp_sequence_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input words
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [rtpst_pkg::IN_TDATA_W-1:0]    in_tdata,  // [15:0] sequence_number
  input  wire logic [rtpst_pkg::IN_TUSER_W-1:0]    in_tuser,  // [1:0] kind
  // result words
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] in_order, [32:1] extended_highest, [64:33] expected_count,
  // [96:65] lost_count, [104:97] lost_fraction, [111:105] zero
  output logic      [rtpst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [rtpst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtpst_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CW = rtpst_pkg::CW;

  // sequencer
  rtpst_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [rtpst_pkg::CFG_W-1:0]  dropout_max_r;
  logic [rtpst_pkg::CFG_W-1:0]  reorder_max_r;
  logic [rtpst_pkg::PROB_W-1:0] min_seq_r;

  // tracker state
  logic [rtpst_pkg::SEQ_W-1:0]  base_r, base_nxt;
  logic [rtpst_pkg::SEQ_W-1:0]  highest_r, highest_nxt;
  logic [rtpst_pkg::BAD_W-1:0]  bad_r, bad_nxt;
  logic [CW-1:0]                wrap_r, wrap_nxt;
  logic [rtpst_pkg::PROB_W-1:0] prob_r, prob_nxt;
  logic [CW-1:0]                recv_r, recv_nxt;
  logic [CW-1:0]                recv_last_r, recv_last_nxt;
  logic [CW-1:0]                exp_last_r, exp_last_nxt;

  // latched item and work registers
  logic [rtpst_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [rtpst_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [CW-1:0]                eint_r, eint_nxt;
  logic [CW-1:0]                rint_r, rint_nxt;
  logic [CW-1:0]                rem_r, rem_nxt;
  logic [rtpst_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // result word registers
  logic                         ord_r, ord_nxt;
  logic [CW-1:0]                ext_r, ext_nxt;
  logic [CW-1:0]                expc_r, expc_nxt;
  logic [CW-1:0]                lost_r, lost_nxt;
  logic [rtpst_pkg::FRAC_W-1:0] frac_r, frac_nxt;

  // shared unit
  logic [CW:0]   alu_a;
  logic [CW-1:0] alu_b;
  logic          alu_sub;
  logic [CW:0]   alu_res;
  logic          alu_ge;

  rtpst_pkg::pkt_dec_t pkt_dec;
  logic                in_acc;
  logic                rep_no_loss;
  logic                div_last;

  assign in_tready  = (state_r == rtpst_pkg::ST_IDLE);
  assign out_tvalid = (state_r == rtpst_pkg::ST_OUT);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tdata  = {{rtpst_pkg::OUT_PAD_W{1'b0}}, frac_r, lost_r, expc_r, ext_r, ord_r};

  assign rep_no_loss = (eint_r == '0) || (rem_r == '0) || rem_r[CW-1];
  assign div_last    = (div_cnt_r == rtpst_pkg::DIV_CNT_W'(rtpst_pkg::FRAC_W - 1));

  rtpst_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  rtpst_pkt_check u_pkt_check (
    .seq         (seq_r),
    .highest     (highest_r),
    .bad         (bad_r),
    .prob        (prob_r),
    .dropout_max (dropout_max_r),
    .reorder_max (reorder_max_r),
    .dec         (pkt_dec)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtpst_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = rtpst_pkg::ST_DECODE;
      end
      rtpst_pkg::ST_DECODE: begin
        if (kind_r == rtpst_pkg::KIND_REPORT) begin
          state_nxt = rtpst_pkg::ST_REP_EXT;
        end else if (kind_r == rtpst_pkg::KIND_PACKET && pkt_dec.wrap) begin
          state_nxt = rtpst_pkg::ST_PKT_WRAP;
        end else if (kind_r == rtpst_pkg::KIND_PACKET && pkt_dec.count) begin
          state_nxt = rtpst_pkg::ST_PKT_RECV;
        end else begin
          state_nxt = rtpst_pkg::ST_OUT;
        end
      end
      rtpst_pkg::ST_PKT_WRAP: state_nxt = rtpst_pkg::ST_PKT_RECV;
      rtpst_pkg::ST_PKT_RECV: state_nxt = rtpst_pkg::ST_OUT;
      rtpst_pkg::ST_REP_EXT:  state_nxt = rtpst_pkg::ST_REP_BASE;
      rtpst_pkg::ST_REP_BASE: state_nxt = rtpst_pkg::ST_REP_EXP;
      rtpst_pkg::ST_REP_EXP:  state_nxt = rtpst_pkg::ST_REP_LOST;
      rtpst_pkg::ST_REP_LOST: state_nxt = rtpst_pkg::ST_REP_EINT;
      rtpst_pkg::ST_REP_EINT: state_nxt = rtpst_pkg::ST_REP_RINT;
      rtpst_pkg::ST_REP_RINT: state_nxt = rtpst_pkg::ST_REP_LINT;
      rtpst_pkg::ST_REP_LINT: state_nxt = rtpst_pkg::ST_REP_SAT;
      rtpst_pkg::ST_REP_SAT: begin
        if (rep_no_loss || alu_ge) state_nxt = rtpst_pkg::ST_OUT;
        else                       state_nxt = rtpst_pkg::ST_REP_DIV;
      end
      rtpst_pkg::ST_REP_DIV: begin
        if (div_last) state_nxt = rtpst_pkg::ST_OUT;
      end
      rtpst_pkg::ST_OUT: begin
        if (out_tready) state_nxt = rtpst_pkg::ST_IDLE;
      end
      default: state_nxt = rtpst_pkg::ST_IDLE;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_a   = {1'b0, wrap_r};
    alu_b   = CW'(rtpst_pkg::SEQ_MOD);
    alu_sub = 1'b0;
    unique case (state_r)
      rtpst_pkg::ST_PKT_RECV: begin
        alu_a = {1'b0, recv_r};
        alu_b = CW'(1);
      end
      rtpst_pkg::ST_REP_EXT: begin
        alu_b = CW'(highest_r);
      end
      rtpst_pkg::ST_REP_BASE: begin
        alu_a   = {1'b0, ext_r};
        alu_b   = CW'(base_r);
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_EXP: begin
        alu_a = {1'b0, expc_r};
        alu_b = CW'(1);
      end
      rtpst_pkg::ST_REP_LOST: begin
        alu_a   = {1'b0, expc_r};
        alu_b   = recv_r;
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_EINT: begin
        alu_a   = {1'b0, expc_r};
        alu_b   = exp_last_r;
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_RINT: begin
        alu_a   = {1'b0, recv_r};
        alu_b   = recv_last_r;
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_LINT: begin
        alu_a   = {1'b0, eint_r};
        alu_b   = rint_r;
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_SAT: begin
        alu_a   = {1'b0, rem_r};
        alu_b   = eint_r;
        alu_sub = 1'b1;
      end
      rtpst_pkg::ST_REP_DIV: begin
        // twice the remainder against the expected interval
        alu_a   = {rem_r, 1'b0};
        alu_b   = eint_r;
        alu_sub = 1'b1;
      end
      default: begin
        // wrap step and idle states keep the defaults
        alu_sub = 1'b0;
      end
    endcase
  end

  // register updates per state
  always_comb begin
    base_nxt      = base_r;
    highest_nxt   = highest_r;
    bad_nxt       = bad_r;
    wrap_nxt      = wrap_r;
    prob_nxt      = prob_r;
    recv_nxt      = recv_r;
    recv_last_nxt = recv_last_r;
    exp_last_nxt  = exp_last_r;
    kind_nxt      = kind_r;
    seq_nxt       = seq_r;
    eint_nxt      = eint_r;
    rint_nxt      = rint_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    ord_nxt       = ord_r;
    ext_nxt       = ext_r;
    expc_nxt      = expc_r;
    lost_nxt      = lost_r;
    frac_nxt      = frac_r;

    unique case (state_r)
      rtpst_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_tuser;
          seq_nxt  = in_tdata;
        end
      end

      rtpst_pkg::ST_DECODE: begin
        // fields without meaning for the item stay zero
        ord_nxt  = 1'b0;
        ext_nxt  = '0;
        expc_nxt = '0;
        lost_nxt = '0;
        frac_nxt = '0;
        unique case (kind_r)
          rtpst_pkg::KIND_PACKET: begin
            ord_nxt = pkt_dec.order;
            if (pkt_dec.set_high)  highest_nxt = seq_r;
            if (pkt_dec.prob_step) prob_nxt = prob_r - rtpst_pkg::PROB_W'(1);
            if (pkt_dec.prob_fail) prob_nxt = min_seq_r - rtpst_pkg::PROB_W'(1);
            if (pkt_dec.mark_bad)  bad_nxt = {1'b0, seq_r + rtpst_pkg::SEQ_W'(1)};
            if (pkt_dec.restart) begin
              base_nxt      = seq_r;
              highest_nxt   = seq_r;
              bad_nxt       = rtpst_pkg::BAD_NONE;
              wrap_nxt      = '0;
              recv_nxt      = '0;
              recv_last_nxt = '0;
              exp_last_nxt  = '0;
            end
          end
          rtpst_pkg::KIND_START: begin
            base_nxt      = seq_r;
            highest_nxt   = seq_r - rtpst_pkg::SEQ_W'(1);
            bad_nxt       = rtpst_pkg::BAD_NONE;
            wrap_nxt      = '0;
            recv_nxt      = '0;
            recv_last_nxt = '0;
            exp_last_nxt  = '0;
            prob_nxt      = min_seq_r;
          end
          default: begin
            // report starts next cycle; unused kind changes nothing
            ord_nxt = 1'b0;
          end
        endcase
      end

      rtpst_pkg::ST_PKT_WRAP: wrap_nxt = alu_res[CW-1:0];
      rtpst_pkg::ST_PKT_RECV: recv_nxt = alu_res[CW-1:0];
      rtpst_pkg::ST_REP_EXT:  ext_nxt  = alu_res[CW-1:0];
      rtpst_pkg::ST_REP_BASE: expc_nxt = alu_res[CW-1:0];
      rtpst_pkg::ST_REP_EXP:  expc_nxt = alu_res[CW-1:0];
      rtpst_pkg::ST_REP_LOST: lost_nxt = alu_res[CW-1:0];

      rtpst_pkg::ST_REP_EINT: begin
        eint_nxt     = alu_res[CW-1:0];
        exp_last_nxt = expc_r;
      end

      rtpst_pkg::ST_REP_RINT: begin
        rint_nxt      = alu_res[CW-1:0];
        recv_last_nxt = recv_r;
      end

      rtpst_pkg::ST_REP_LINT: rem_nxt = alu_res[CW-1:0];

      rtpst_pkg::ST_REP_SAT: begin
        // zero, saturated, or start of the divide
        div_cnt_nxt = '0;
        if (rep_no_loss)  frac_nxt = '0;
        else if (alu_ge)  frac_nxt = rtpst_pkg::FRAC_SAT;
        else              frac_nxt = '0;
      end

      rtpst_pkg::ST_REP_DIV: begin
        // one quotient bit per cycle
        frac_nxt    = {frac_r[rtpst_pkg::FRAC_W-2:0], alu_ge};
        rem_nxt     = alu_ge ? alu_res[CW-1:0] : {rem_r[CW-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + rtpst_pkg::DIV_CNT_W'(1);
      end

      default: begin
        // result word waits for the receiver
        ord_nxt = ord_r;
      end
    endcase
  end

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtpst_pkg::ST_IDLE;
      base_r      <= '0;
      highest_r   <= rtpst_pkg::HIGHEST_RST;
      bad_r       <= rtpst_pkg::BAD_NONE;
      wrap_r      <= '0;
      prob_r      <= rtpst_pkg::PROB_RST;
      recv_r      <= '0;
      recv_last_r <= '0;
      exp_last_r  <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      highest_r   <= highest_nxt;
      bad_r       <= bad_nxt;
      wrap_r      <= wrap_nxt;
      prob_r      <= prob_nxt;
      recv_r      <= recv_nxt;
      recv_last_r <= recv_last_nxt;
      exp_last_r  <= exp_last_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropout_max_r <= rtpst_pkg::MAX_DROPOUT_RST;
      reorder_max_r <= rtpst_pkg::MAX_MISORDER_RST;
      min_seq_r     <= rtpst_pkg::MIN_SEQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtpst_pkg::CFG_MAX_DROPOUT:  dropout_max_r <= cfg_wdata;
        rtpst_pkg::CFG_MAX_MISORDER: reorder_max_r <= cfg_wdata;
        rtpst_pkg::CFG_MIN_SEQ:      min_seq_r     <= cfg_wdata[rtpst_pkg::PROB_W-1:0];
        default:                     min_seq_r     <= min_seq_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    seq_r  <= seq_nxt;
    eint_r <= eint_nxt;
    rint_r <= rint_nxt;
    rem_r  <= rem_nxt;
    ord_r  <= ord_nxt;
    ext_r  <= ext_nxt;
    expc_r <= expc_nxt;
    lost_r <= lost_nxt;
    frac_r <= frac_nxt;
  end

`ifndef NO_ASSERTIONS
  // the block never takes a word while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result word is pending");

  // an accepted word is decoded in the next cycle
  a_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == rtpst_pkg::ST_DECODE)
    else $error("accepted word not decoded");

  // divider remainder stays below the expected interval
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtpst_pkg::ST_REP_DIV |-> rem_r < eint_r)
    else $error("divider remainder out of range");

  // in_order is only ever reported for packets
  a_order_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ord_r |-> kind_r == rtpst_pkg::KIND_PACKET)
    else $error("in_order set for a non-packet word");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for rtp_sequence_tracker, with a stream driver and a monitor
// a built-in sequence tracking predictor runs on every accepted input word
// depends on rtpst_pkg and rtp_sequence_tracker
`timescale 1ns / 1ps

module tb;

  localparam int KIND_W      = rtpst_pkg::KIND_W;
  localparam int SEQ_W       = rtpst_pkg::SEQ_W;
  localparam int BAD_W       = rtpst_pkg::BAD_W;
  localparam int CW          = rtpst_pkg::CW;
  localparam int FRAC_W      = rtpst_pkg::FRAC_W;
  localparam int PROB_W      = rtpst_pkg::PROB_W;
  localparam int CFG_W       = rtpst_pkg::CFG_W;
  localparam int CFG_IDX_W   = rtpst_pkg::CFG_IDX_W;
  localparam int IN_TDATA_W  = rtpst_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W  = rtpst_pkg::IN_TUSER_W;
  localparam int OUT_DATA_W  = rtpst_pkg::OUT_DATA_W;
  localparam int OUT_TDATA_W = rtpst_pkg::OUT_TDATA_W;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic              wait_drain;
  } item_t;

  typedef struct {
    logic              in_order;
    logic [CW-1:0]     ext_high;
    logic [CW-1:0]     exp_cnt;
    logic [CW-1:0]     lost_cnt;
    logic [FRAC_W-1:0] lost_frac;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  rtp_sequence_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers and the tracker state
  logic [CFG_W-1:0]  lim_dropout;
  logic [CFG_W-1:0]  lim_misorder;
  logic [PROB_W-1:0] lim_minseq;
  logic [SEQ_W-1:0]  src_base;
  logic [SEQ_W-1:0]  src_high;
  logic [BAD_W-1:0]  src_bad;
  logic [CW-1:0]     src_wraps;
  logic [PROB_W-1:0] probation;
  logic [CW-1:0]     rcv_total;
  logic [CW-1:0]     rcv_at_rep;
  logic [CW-1:0]     exp_at_rep;

  // bench bookkeeping
  item_t       pending_items[$];
  result_t     awaited_words[$];
  item_t       next_item;
  result_t     predicted;
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 47;
  int unsigned errors = 0;
  logic [SEQ_W-1:0] gen_cursor = '0;

  function automatic void reset_tracker();
    lim_dropout  = rtpst_pkg::MAX_DROPOUT_RST;
    lim_misorder = rtpst_pkg::MAX_MISORDER_RST;
    lim_minseq   = rtpst_pkg::MIN_SEQ_RST;
    src_base     = '0;
    src_high     = rtpst_pkg::HIGHEST_RST;
    src_bad      = rtpst_pkg::BAD_NONE;
    src_wraps    = '0;
    probation    = rtpst_pkg::PROB_RST;
    rcv_total    = '0;
    rcv_at_rep   = '0;
    exp_at_rep   = '0;
  endfunction

  function automatic void restart_source(input logic [SEQ_W-1:0] s);
    src_base   = s;
    src_high   = s;
    src_bad    = rtpst_pkg::BAD_NONE;
    src_wraps  = '0;
    rcv_total  = '0;
    rcv_at_rep = '0;
    exp_at_rep = '0;
  endfunction

  // packet path: probation, forward gap, large jump / resync, reject
  function automatic logic accept_packet(input logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] gap;
    gap = s - src_high;
    if (probation != '0) begin
      if (s == src_high + 16'd1) begin
        probation = probation - 4'd1;
        src_high = s;
        if (probation == '0) begin
          restart_source(s);
          rcv_total = rcv_total + 1;
        end
        return 1'b1;
      end
      probation = lim_minseq - 4'd1;
      src_high = s;
      return 1'b0;
    end
    if ({1'b0, gap} < {2'b0, lim_dropout}) begin
      if (s < src_high) src_wraps = src_wraps + 32'h10000;
      src_high = s;
    end else if ({1'b0, gap} <= rtpst_pkg::SEQ_MOD - {2'b0, lim_misorder}) begin
      if ({1'b0, s} == src_bad) begin
        restart_source(s);
      end else begin
        src_bad = {1'b0, s + 16'd1};
        return 1'b0;
      end
    end else begin
      return 1'b0;
    end
    rcv_total = rcv_total + 1;
    return gap == 16'd1;
  endfunction

  // report path: counters and lost fraction of the interval
  function automatic result_t report_counts();
    result_t r;
    logic [CW-1:0] eint, rint, lint;
    logic [CW+FRAC_W-1:0] quo;
    r.in_order = 1'b0;
    r.ext_high = src_wraps + {16'b0, src_high};
    r.exp_cnt  = r.ext_high - {16'b0, src_base} + 1;
    r.lost_cnt = r.exp_cnt - rcv_total;
    eint = r.exp_cnt - exp_at_rep;
    rint = rcv_total - rcv_at_rep;
    lint = eint - rint;
    exp_at_rep = r.exp_cnt;
    rcv_at_rep = rcv_total;
    if (eint == '0 || lint == '0 || lint[CW-1]) begin
      r.lost_frac = '0;
    end else if (lint >= eint) begin
      r.lost_frac = rtpst_pkg::FRAC_SAT;
    end else begin
      quo = {lint, {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, eint};
      r.lost_frac = quo[FRAC_W-1:0];
    end
    return r;
  endfunction

  function automatic result_t predict_result(input logic [KIND_W-1:0] k,
                                             input logic [SEQ_W-1:0] s);
    result_t r;
    r = '{1'b0, '0, '0, '0, '0};
    case (k)
      rtpst_pkg::KIND_PACKET: begin
        r.in_order = accept_packet(s);
      end
      rtpst_pkg::KIND_REPORT: begin
        r = report_counts();
      end
      rtpst_pkg::KIND_START: begin
        restart_source(s);
        src_high = s - 16'd1;
        probation = lim_minseq;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_item(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s);
    item_t it;
    it = '{k, s, 1'b0};
    pending_items = {pending_items, it};
  endfunction

  // mostly well-formed runs with random content, some reordering and noise
  function automatic void add_random_items();
    int unsigned pick;
    int unsigned run;
    logic [SEQ_W-1:0] s;
    pick = $urandom_range(99);
    if (pick < 3) begin
      s = $urandom_range(1) ? 16'(65535 - $urandom_range(40)) : 16'($urandom);
      add_item(rtpst_pkg::KIND_START, s);
      gen_cursor = s;
      run = $urandom_range(16, 2);
      repeat (run) begin
        add_item(rtpst_pkg::KIND_PACKET, gen_cursor);
        gen_cursor = gen_cursor + 16'd1;
      end
    end else if (pick < 13) begin
      add_item(rtpst_pkg::KIND_REPORT, 16'($urandom));
    end else if (pick < 15) begin
      add_item(KIND_UNUSED, 16'($urandom));
    end else if (pick < 70) begin
      add_item(rtpst_pkg::KIND_PACKET, gen_cursor);
      gen_cursor = gen_cursor + 16'd1;
    end else if (pick < 76) begin
      add_item(rtpst_pkg::KIND_PACKET, gen_cursor - 16'd1);
    end else if (pick < 82) begin
      add_item(rtpst_pkg::KIND_PACKET, gen_cursor - 16'($urandom_range(200, 2)));
    end else if (pick < 90) begin
      s = gen_cursor + 16'($urandom_range(4000, 1));
      add_item(rtpst_pkg::KIND_PACKET, s);
      gen_cursor = s + 16'd1;
    end else if (pick < 95) begin
      // large jump, then its successor to force a resync
      s = gen_cursor + 16'($urandom_range(60000, 4000));
      add_item(rtpst_pkg::KIND_PACKET, s);
      add_item(rtpst_pkg::KIND_PACKET, s + 16'd1);
      gen_cursor = s + 16'd2;
    end else begin
      add_item(rtpst_pkg::KIND_PACKET, 16'($urandom));
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rtpst_pkg::CFG_MAX_DROPOUT:  lim_dropout = val;
      rtpst_pkg::CFG_MAX_MISORDER: lim_misorder = val;
      rtpst_pkg::CFG_MIN_SEQ:      lim_minseq = val[PROB_W-1:0];
      default: ;
    endcase
  endtask

  // all words sent, all results in, then the longest latency once more
  // checked at the falling edge, after the clocked processes have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || accepted_cnt != results_cnt)
      @(negedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] dropout, input logic [CFG_W-1:0] misorder,
                           input logic [CFG_W-1:0] minseq, input int unsigned snd_pct,
                           input int unsigned rcv_pct, input int unsigned n_items);
    int unsigned start_len;
    write_reg(rtpst_pkg::CFG_MAX_DROPOUT, dropout);
    write_reg(rtpst_pkg::CFG_MAX_MISORDER, misorder);
    write_reg(rtpst_pkg::CFG_MIN_SEQ, minseq);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start_len = pending_items.size();
    while (pending_items.size() - start_len < n_items) begin
      add_random_items();
      // the last word of a batch that ends 40 to 42 words into the phase waits until the block has drained
      if (pending_items.size() - start_len >= 40 && pending_items.size() - start_len < 43)
        pending_items[$].wait_drain = 1'b1;
    end
    wait_idle();
  endtask

  function automatic void compare_word(input logic [OUT_TDATA_W-1:0] w);
    result_t e;
    if (awaited_words.size() == 0) begin
      $error("result word with no expectation waiting: %h", w);
      errors++;
      return;
    end
    e = awaited_words.pop_front();
    if (w[0] !== e.in_order) begin
      $error("in_order expected %0d got %0d", e.in_order, w[0]);
      errors++;
    end
    if (w[CW:1] !== e.ext_high) begin
      $error("extended_highest expected %0d got %0d", e.ext_high, w[CW:1]);
      errors++;
    end
    if (w[2*CW:CW+1] !== e.exp_cnt) begin
      $error("expected_count expected %0d got %0d", e.exp_cnt, w[2*CW:CW+1]);
      errors++;
    end
    if (w[3*CW:2*CW+1] !== e.lost_cnt) begin
      $error("lost_count expected %0d got %0d", $signed(e.lost_cnt), $signed(w[3*CW:2*CW+1]));
      errors++;
    end
    if (w[3*CW+FRAC_W:3*CW+1] !== e.lost_frac) begin
      $error("lost_fraction expected %0d got %0d", e.lost_frac, w[3*CW+FRAC_W:3*CW+1]);
      errors++;
    end
    if (w[OUT_TDATA_W-1:OUT_DATA_W] !== '0) begin
      $error("padding expected 0 got %h", w[OUT_TDATA_W-1:OUT_DATA_W]);
      errors++;
    end
  endfunction

  // driver: offers queued words, predicts each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      accepted_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = predict_result(in_tuser, in_tdata);
        awaited_words = {awaited_words, predicted};
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending_items[0].wait_drain || (!in_tvalid && accepted_cnt == results_cnt))) begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_item.kind;
          in_tdata  <= next_item.seq;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words, random stalls and two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      results_cnt <= 0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        compare_word(out_tdata);
        results_cnt <= results_cnt + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && (results_cnt == 150 || results_cnt == 1000)) begin
        hold_left <= 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, directed words, then random phases over several settings
  initial begin
    reset_tracker();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // probation pass, gap zero, forward gap, reorder, backward across zero
    add_item(rtpst_pkg::KIND_START, 16'd0);
    add_item(rtpst_pkg::KIND_PACKET, 16'd0);
    add_item(rtpst_pkg::KIND_PACKET, 16'd1);
    add_item(rtpst_pkg::KIND_PACKET, 16'd2);
    add_item(rtpst_pkg::KIND_PACKET, 16'd2);
    add_item(rtpst_pkg::KIND_PACKET, 16'd5);
    add_item(rtpst_pkg::KIND_PACKET, 16'd4);
    add_item(rtpst_pkg::KIND_REPORT, 16'd0);
    add_item(rtpst_pkg::KIND_PACKET, 16'd65535);
    add_item(rtpst_pkg::KIND_REPORT, 16'd65535);
    // wrap of the sequence space
    add_item(rtpst_pkg::KIND_START, 16'd65534);
    add_item(rtpst_pkg::KIND_PACKET, 16'd65534);
    add_item(rtpst_pkg::KIND_PACKET, 16'd65535);
    add_item(rtpst_pkg::KIND_PACKET, 16'd0);
    add_item(rtpst_pkg::KIND_PACKET, 16'd1);
    // large jump and resync
    add_item(rtpst_pkg::KIND_PACKET, 16'd30000);
    add_item(rtpst_pkg::KIND_PACKET, 16'd30001);
    add_item(rtpst_pkg::KIND_REPORT, 16'd0);
    // empty interval, probation failure, saturated fraction
    add_item(rtpst_pkg::KIND_START, 16'd100);
    add_item(rtpst_pkg::KIND_REPORT, 16'd0);
    add_item(rtpst_pkg::KIND_PACKET, 16'd500);
    add_item(rtpst_pkg::KIND_REPORT, 16'd0);
    // unused kind
    add_item(KIND_UNUSED, 16'd65535);
    add_item(rtpst_pkg::KIND_REPORT, 16'd65535);
    wait_idle();

    run_phase(15'd3000, 15'd100, 15'd2, 23, 47, 400);
    run_phase(15'd32767, 15'd32767, 15'd15, 23, 47, 250);
    run_phase(15'd1, 15'd1, 15'd1, 47, 23, 250);
    run_phase(15'd200, 15'd50, 15'd4, 47, 23, 300);
    run_phase(15'd10000, 15'd3000, 15'd0, 0, 0, 150);
    run_phase(15'd3000, 15'd100, 15'd2, 0, 0, 400);
    run_phase(15'd64, 15'd8, 15'd3, 0, 0, 200);

    if (awaited_words.size() != 0) begin
      $error("%0d result words never arrived", awaited_words.size());
      errors++;
    end
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/rtpst_pkg.sv
rtl/rtpst_alu.sv
rtl/rtpst_pkt_check.sv
rtl/rtp_sequence_tracker.sv
bench/tb.sv
